// ===== hw/rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HEF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HEF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/hef_pkg.sv =====
// ----------------------------------------------------------------------------
// hef_pkg
// Shared codes, reset values and the command/status structs of the FTCS block.
// ----------------------------------------------------------------------------
package hef_pkg;

    // Opcodes
    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Register indexes
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_GRID_STEP   = 3'd1;
    localparam logic [2:0] CFG_DIFF_GAIN   = 3'd2;
    localparam logic [2:0] CFG_POINTS      = 3'd3;
    localparam logic [2:0] CFG_CONV_THRESH = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_TIME_STEP   = 32'd0;
    localparam logic [31:0] RST_GRID_STEP   = 32'd4194304;
    localparam logic [31:0] RST_DIFF_GAIN   = 32'd0;
    localparam logic [10:0] RST_POINTS      = 11'd1024;
    localparam logic [31:0] RST_CONV_THRESH = 32'd168;

    // pi in Q2.30 for the quarter-wave table
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    // Widest grid address and the point count width
    localparam int ADDR_MAX_W = 16;
    localparam int NPTS_W     = 11;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_STEP,
        RES_READ,
        RES_BAD
    } res_kind_t;

    // Controller to datapath
    typedef struct packed {
        logic                  clr_we;
        logic                  rd_en;
        logic                  walk;
        logic                  step_start;
        logic                  sqrt_start;
        logic                  load_res;
        res_kind_t             kind;
        logic [ADDR_MAX_W-1:0] addr;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [NPTS_W-1:0] n_eff;
        logic              pipe_busy;
        logic              sqrt_busy;
    } dp_stat_t;

endpackage

// ===== hw/rtl/heat_equation_ftcs_step.sv =====
// ----------------------------------------------------------------------------
// heat_equation_ftcs_step
// One explicit FTCS step of the 1-D heat equation over a Q8.24 grid.
// ----------------------------------------------------------------------------
// One command at a time. A step walks the grid memory at one point per cycle
// through a seven-stage update pipeline, then runs a bit-serial root on the
// summed squared change. A clear writes one memory word per cycle over the
// whole grid. After reset a zeroing pass over the whole grid runs before the
// first command is taken; register writes are taken at any time.
module heat_equation_ftcs_step #(
    parameter int GRID_POINTS        = 1024,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  opcode,
    input  logic [9:0]  point_index,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] point_value,
    output logic [31:0] error_norm,
    output logic        converged,
    output logic        status
);

    hef_pkg::ctrl_cmd_t dp_cmd;
    hef_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    hef_ctrl #(
        .GRID_POINTS (GRID_POINTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .opcode      (opcode),
        .point_index (point_index),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .stat        (stat),
        .dp_cmd      (dp_cmd)
    );

    hef_datapath #(
        .GRID_POINTS        (GRID_POINTS),
        .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .dp_cmd      (dp_cmd),
        .stat        (stat),
        .point_value (point_value),
        .error_norm  (error_norm),
        .converged   (converged),
        .status      (status)
    );

endmodule

// ===== hw/rtl/hef_ram.sv =====
// ----------------------------------------------------------------------------
// hef_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hef_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/hef_sqrt.sv =====
// ----------------------------------------------------------------------------
// hef_sqrt
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module hef_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic [35:0] diff;

    // one restoring step: bring down two bits, try root*4+1
    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[63:62]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= diff[33:0];
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh[33:0];
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ===== hw/rtl/hef_ctrl.sv =====
// ----------------------------------------------------------------------------
// hef_ctrl
// Sequencer: clearing sweep, grid walk, drain, root, read and result hand-off.
// ----------------------------------------------------------------------------
module hef_ctrl #(
    parameter int GRID_POINTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          opcode,
    input  logic [9:0]          point_index,
    output logic                res_valid,
    input  logic                res_stall,
    input  hef_pkg::dp_stat_t   stat,
    output hef_pkg::ctrl_cmd_t  dp_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_ROOT,
        S_DONE
    } state_t;

    localparam logic [hef_pkg::ADDR_MAX_W-1:0] LAST_ADDR =
        hef_pkg::ADDR_MAX_W'(GRID_POINTS - 1);
    localparam logic [hef_pkg::ADDR_MAX_W-1:0] ADDR_ONE = hef_pkg::ADDR_MAX_W'(1);

    state_t                          state_reg, state_next;
    logic [hef_pkg::ADDR_MAX_W-1:0]  cnt_reg, cnt_next;
    hef_pkg::res_kind_t              kind_reg, kind_next;
    logic                            clr_cmd_reg, clr_cmd_next;
    logic                            res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        clr_cmd_next   = clr_cmd_reg;
        res_valid_next = res_valid_reg && res_stall;
        dp_cmd         = '0;
        dp_cmd.kind    = kind_reg;

        unique case (state_reg)
            // zero sweep, after reset or on a clear command
            S_CLEAR:
            begin
                dp_cmd.clr_we = 1'b1;
                dp_cmd.addr   = cnt_reg;
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = clr_cmd_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_ONE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cnt_next     = '0;
                    clr_cmd_next = 1'b0;
                    kind_next    = hef_pkg::RES_ZERO;
                    state_next   = S_DONE;
                    case (opcode)
                        hef_pkg::OP_STEP:
                        begin
                            dp_cmd.step_start = 1'b1;
                            state_next        = S_WALK;
                        end
                        hef_pkg::OP_READ:
                        begin
                            if ({1'b0, point_index} < stat.n_eff)
                            begin
                                dp_cmd.rd_en = 1'b1;
                                dp_cmd.addr  = hef_pkg::ADDR_MAX_W'(point_index);
                                kind_next    = hef_pkg::RES_READ;
                            end
                            else
                            begin
                                kind_next = hef_pkg::RES_BAD;
                            end
                        end
                        hef_pkg::OP_CLEAR:
                        begin
                            clr_cmd_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        default:
                        begin
                            kind_next = hef_pkg::RES_ZERO;
                        end
                    endcase
                end
            end
            // one old value read per cycle
            S_WALK:
            begin
                if (cnt_reg < hef_pkg::ADDR_MAX_W'(stat.n_eff))
                begin
                    dp_cmd.rd_en = 1'b1;
                    dp_cmd.walk  = 1'b1;
                    dp_cmd.addr  = cnt_reg;
                    cnt_next     = cnt_reg + ADDR_ONE;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    dp_cmd.sqrt_start = 1'b1;
                    state_next        = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (!stat.sqrt_busy)
                begin
                    kind_next  = hef_pkg::RES_STEP;
                    state_next = S_DONE;
                end
            end
            // load the output word once the register is free
            S_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    dp_cmd.load_res = 1'b1;
                    res_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cnt_reg       <= '0;
            kind_reg      <= hef_pkg::RES_ZERO;
            clr_cmd_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            kind_reg      <= kind_next;
            clr_cmd_reg   <= clr_cmd_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

endmodule

// ===== hw/rtl/hef_datapath.sv =====
// ----------------------------------------------------------------------------
// hef_datapath
// Registers, grid memory, FTCS update pipeline, norm root and output word.
// ----------------------------------------------------------------------------
module hef_datapath #(
    parameter int GRID_POINTS        = 1024,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  hef_pkg::ctrl_cmd_t  dp_cmd,
    output hef_pkg::dp_stat_t   stat,
    output logic [31:0]         point_value,
    output logic [31:0]         error_norm,
    output logic                converged,
    output logic                status
);

    localparam int AW  = $clog2(GRID_POINTS);
    localparam int IW  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PW  = 32 + IW;

    typedef logic [24:0] rom_t [0:SINE_TABLE_ENTRIES];

    // quarter-wave sine, Q1.24, built at elaboration by Taylor series
    function automatic rom_t build_rom();
        rom_t               tab;
        logic [63:0]        theta;
        logic [63:0]        th2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++)
        begin
            theta = (hef_pkg::PI_Q30 * 64'(k)) / 64'(2 * SINE_TABLE_ENTRIES);
            th2   = (theta * theta) >> 30;
            term  = theta;
            acc   = $signed(theta);
            for (int i = 0; i < 9; i++)
            begin
                term = ((term * th2) >> 30) / 64'((2 * i + 2) * (2 * i + 3));
                if ((i % 2) == 0)
                begin
                    acc = acc - $signed(term);
                end
                else
                begin
                    acc = acc + $signed(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            if (acc > 64'sd1073741824)
            begin
                acc = 64'sd1073741824;
            end
            tab[k] = 25'((acc + 64'sd32) >>> 6);
        end
        return tab;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [31:0] dt_reg, dx_reg, gain_reg, thresh_reg;
    logic [10:0] points_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg     <= hef_pkg::RST_TIME_STEP;
            dx_reg     <= hef_pkg::RST_GRID_STEP;
            gain_reg   <= hef_pkg::RST_DIFF_GAIN;
            points_reg <= hef_pkg::RST_POINTS;
            thresh_reg <= hef_pkg::RST_CONV_THRESH;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                hef_pkg::CFG_TIME_STEP:   dt_reg     <= cfg_data;
                hef_pkg::CFG_GRID_STEP:   dx_reg     <= cfg_data;
                hef_pkg::CFG_DIFF_GAIN:   gain_reg   <= cfg_data;
                hef_pkg::CFG_POINTS:      points_reg <= cfg_data[10:0];
                hef_pkg::CFG_CONV_THRESH: thresh_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // effective point count
    logic [10:0] n_eff;
    always_comb
    begin
        if (int'(points_reg) >= GRID_POINTS)
        begin
            n_eff = 11'(GRID_POINTS);
        end
        else
        begin
            n_eff = points_reg;
        end
    end

    // grid memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_q;

    // pipeline registers
    logic          tag_v_reg;
    logic [AW-1:0] tag_a_reg;
    logic [31:0]   prev_reg, cur_reg;
    logic [32:0]   phase_reg;

    logic          v1_reg, lapneg1_reg, sneg1_reg;
    logic [33:0]   lapmag1_reg;
    logic [31:0]   cur1_reg;
    logic [AW-1:0] x1_reg;
    logic [IW-1:0] idx1_reg;

    logic          v2_reg, lapneg2_reg, sneg2_reg;
    logic [41:0]   hi2_reg;
    logic [55:0]   lo2_reg;
    logic [24:0]   rom2_reg;
    logic [31:0]   cur2_reg;
    logic [AW-1:0] x2_reg;

    logic          v3_reg, lapneg3_reg, sneg3_reg;
    logic [42:0]   diff3_reg;
    logic [56:0]   src3_reg;
    logic [31:0]   cur3_reg;
    logic [AW-1:0] x3_reg;

    logic          v4_reg;
    logic [31:0]   nv4_reg, cur4_reg;
    logic [AW-1:0] x4_reg;

    logic          v5_reg;
    logic [31:0]   dmag5_reg;

    logic          v6_reg;
    logic [63:0]   sq6_reg;

    logic [63:0]   sum_reg;

    // window and phase fold
    logic signed [33:0] lap_w;
    logic [33:0]        lapmag_w;
    logic [31:0]        fold_w;
    logic [PW-1:0]      prod_w;
    logic               take_w;

    always_comb
    begin
        lap_w    = $signed({{2{ram_q[31]}}, ram_q}) + $signed({{2{prev_reg[31]}}, prev_reg})
                 - $signed({cur_reg[31], cur_reg, 1'b0});
        lapmag_w = lap_w[33] ? 34'(-lap_w) : 34'(lap_w);
        fold_w   = phase_reg[31] ? (32'd0 - phase_reg[31:0]) : phase_reg[31:0];
        prod_w   = PW'(fold_w) * PW'(SINE_TABLE_ENTRIES);
        take_w   = tag_v_reg && (tag_a_reg >= AW'(2));
    end

    // new value, saturated
    logic signed [45:0] diffs_w, srcs_w, sum46_w;
    logic [31:0]        nv_w;
    always_comb
    begin
        diffs_w = lapneg3_reg ? -$signed(46'(diff3_reg)) : $signed(46'(diff3_reg));
        srcs_w  = sneg3_reg ? -$signed(46'(src3_reg[56:32])) : $signed(46'(src3_reg[56:32]));
        sum46_w = $signed({{14{cur3_reg[31]}}, cur3_reg}) + diffs_w + srcs_w;
        if (sum46_w > 46'sd2147483647)
        begin
            nv_w = 32'h7FFF_FFFF;
        end
        else if (sum46_w < -46'sd2147483648)
        begin
            nv_w = 32'h8000_0000;
        end
        else
        begin
            nv_w = sum46_w[31:0];
        end
    end

    // change magnitude and saturating sum
    logic signed [32:0] d_w;
    logic [64:0]        acc_w;
    always_comb
    begin
        d_w   = $signed({nv4_reg[31], nv4_reg}) - $signed({cur4_reg[31], cur4_reg});
        acc_w = {1'b0, sum_reg} + {1'b0, sq6_reg};
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_v_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
        end
        else
        begin
            tag_v_reg <= dp_cmd.walk;
            v1_reg    <= take_w;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        tag_a_reg <= AW'(dp_cmd.addr);

        if (dp_cmd.step_start)
        begin
            phase_reg <= {1'b0, dx_reg};
            sum_reg   <= '0;
        end
        else
        begin
            if (take_w)
            begin
                phase_reg <= phase_reg + {1'b0, dx_reg};
            end
            if (v6_reg)
            begin
                sum_reg <= acc_w[64] ? '1 : acc_w[63:0];
            end
        end

        if (tag_v_reg)
        begin
            prev_reg <= cur_reg;
            cur_reg  <= ram_q;
        end

        // stage 1: Laplacian and table index
        lapneg1_reg <= lap_w[33];
        lapmag1_reg <= lapmag_w;
        cur1_reg    <= cur_reg;
        x1_reg      <= tag_a_reg - AW'(1);
        sneg1_reg   <= phase_reg[32];
        idx1_reg    <= prod_w[31 +: IW];

        // stage 2: gain partial products, table read
        hi2_reg     <= 42'(lapmag1_reg[33:24]) * 42'(gain_reg);
        lo2_reg     <= 56'(lapmag1_reg[23:0]) * 56'(gain_reg);
        rom2_reg    <= SINE_ROM[idx1_reg];
        lapneg2_reg <= lapneg1_reg;
        sneg2_reg   <= sneg1_reg;
        cur2_reg    <= cur1_reg;
        x2_reg      <= x1_reg;

        // stage 3: diffusion magnitude, source product
        diff3_reg   <= 43'(hi2_reg) + 43'(lo2_reg[55:24]);
        src3_reg    <= 57'(rom2_reg) * 57'(dt_reg);
        lapneg3_reg <= lapneg2_reg;
        sneg3_reg   <= sneg2_reg;
        cur3_reg    <= cur2_reg;
        x3_reg      <= x2_reg;

        // stage 4: new value
        nv4_reg  <= nv_w;
        cur4_reg <= cur3_reg;
        x4_reg   <= x3_reg;

        // stage 5 and 6: squared change
        dmag5_reg <= d_w[32] ? 32'(-d_w) : 32'(d_w);
        sq6_reg   <= 64'(dmag5_reg) * 64'(dmag5_reg);
    end

    // write port: clearing sweep or write-back
    always_comb
    begin
        if (dp_cmd.clr_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = AW'(dp_cmd.addr);
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = v4_reg;
            ram_waddr = x4_reg;
            ram_wdata = nv4_reg;
        end
    end

    hef_ram #(
        .WIDTH (32),
        .DEPTH (GRID_POINTS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (dp_cmd.rd_en),
        .raddr (AW'(dp_cmd.addr)),
        .rdata (ram_q)
    );

    logic        sqrt_busy;
    logic [31:0] norm;

    hef_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dp_cmd.sqrt_start),
        .radicand (sum_reg),
        .busy     (sqrt_busy),
        .root     (norm)
    );

    // output word, every field set once per load
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load_res)
        begin
            unique case (dp_cmd.kind)
                hef_pkg::RES_STEP:
                begin
                    point_value <= '0;
                    error_norm  <= norm;
                    converged   <= (norm < thresh_reg);
                    status      <= 1'b0;
                end
                hef_pkg::RES_READ:
                begin
                    point_value <= ram_q;
                    error_norm  <= '0;
                    converged   <= 1'b0;
                    status      <= 1'b0;
                end
                hef_pkg::RES_BAD:
                begin
                    point_value <= '0;
                    error_norm  <= '0;
                    converged   <= 1'b0;
                    status      <= 1'b1;
                end
                default:
                begin
                    point_value <= '0;
                    error_norm  <= '0;
                    converged   <= 1'b0;
                    status      <= 1'b0;
                end
            endcase
        end
    end

    assign stat.n_eff     = n_eff;
    assign stat.pipe_busy = tag_v_reg | v1_reg | v2_reg | v3_reg | v4_reg | v5_reg | v6_reg;
    assign stat.sqrt_busy = sqrt_busy;

endmodule

// ===== hw/rtl/hef_checker.sv =====
// ----------------------------------------------------------------------------
// hef_checker
// Port-level checks on the result word of the FTCS block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hef_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] point_value,
    input logic [31:0] error_norm,
    input logic        converged,
    input logic        status
);

    // a held word stays put
    `HEF_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(point_value) && $stable(error_norm), "result word changed while stalled")

    // a read word carries no step figures
    `HEF_ASSERT(a_read_clean, res_valid && (point_value != 32'd0) |-> (error_norm == 32'd0) && !converged && !status, "read word mixed with step fields")

    // a bad read flags alone
    `HEF_ASSERT(a_bad_clean, res_valid && status |-> (point_value == 32'd0) && (error_norm == 32'd0) && !converged, "range error word not clean")

    // nothing offered while in reset
    `HEF_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !res_valid, "result offered during reset")

endmodule

bind heat_equation_ftcs_step hef_checker u_hef_checker (.*);

// ===== tb/heat_equation_ftcs_step_test.sv =====
// ----------------------------------------------------------------------------
// heat_equation_ftcs_step_test
// Self-checking bench for the FTCS heat step block. A behavioural copy of the
// grid, sine table and register file predicts every result word. Each
// returned word is compared with the oldest prediction. Directed cases come
// first, then random traffic under three sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module heat_equation_ftcs_step_test;

    localparam int NPTS      = 1024;
    localparam int NSINE     = 1024;
    localparam int IDLE_WAIT = 60;
    localparam int WDOG_MAX  = 20000;
    localparam logic [1:0] OP_NONE = 2'd3;

    typedef struct {
        logic [31:0] point_value;
        logic [31:0] error_norm;
        logic        converged;
        logic        status;
    } heat_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  opcode      = '0;
    logic [9:0]  point_index = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [31:0] point_value;
    logic [31:0] error_norm;
    logic        converged;
    logic        status;

    // Shadow of the block's state and registers
    int          shadow_grid [NPTS];
    int          sine_rom [NSINE+1];
    logic [31:0] sh_time_step;
    logic [31:0] sh_grid_step;
    logic [31:0] sh_diff_gain;
    logic [10:0] sh_points;
    logic [31:0] sh_threshold;

    heat_result_t expected_results [$];
    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;
    int steps_sent = 0, reads_sent = 0, clears_sent = 0, cfg_writes = 0;
    int quiet_cycles = 0;

    heat_equation_ftcs_step DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .opcode(opcode), .point_index(point_index),
        .res_valid(res_valid), .res_stall(res_stall),
        .point_value(point_value), .error_norm(error_norm),
        .converged(converged), .status(status)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Quarter-wave sine table, Taylor series in Q2.30
    function automatic void build_sine_rom();
        longint unsigned theta, th2, term;
        longint acc;
        for (int k = 0; k <= NSINE; k++)
        begin
            theta = (64'(hef_pkg::PI_Q30) * longint'(k)) / (2 * NSINE);
            th2   = (theta * theta) >> 30;
            term  = theta;
            acc   = longint'(theta);
            for (int i = 0; i < 9; i++)
            begin
                term = ((term * th2) >> 30) / longint'((2*i + 2) * (2*i + 3));
                if ((i & 1) == 0) acc -= longint'(term);
                else              acc += longint'(term);
            end
            if (acc < 0) acc = 0;
            if (acc > (64'sd1 << 30)) acc = 64'sd1 << 30;
            sine_rom[k] = int'((acc + 32) >>> 6);
        end
    endfunction

    function automatic longint sine_at_point(int x);
        longint unsigned p, r, t, idx;
        longint v;
        p   = longint'(x) * longint'({32'd0, sh_grid_step});
        r   = p & 64'hFFFF_FFFF;
        t   = (r < 64'h8000_0000) ? r : (64'h1_0000_0000 - r);
        idx = (t * NSINE) >> 31;
        if (idx > NSINE) idx = NSINE;
        v   = longint'(sine_rom[idx]);
        return p[32] ? -v : v;
    endfunction

    // Signed value times unsigned gain, shifted, magnitude truncated
    function automatic longint scale_toward_zero(longint a, logic [31:0] g, int sh);
        longint unsigned mag, lowmask, r;
        mag     = (a < 0) ? longint'(0) - a : a;
        lowmask = (64'd1 << sh) - 1;
        r = (mag >> sh) * {32'd0, g} + (((mag & lowmask) * {32'd0, g}) >> sh);
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [31:0] floor_sqrt64(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res[31:0];
    endfunction

    // Expected result of one command; updates the shadow grid
    function automatic heat_result_t model_command(logic [1:0] op, logic [9:0] idx);
        heat_result_t res;
        int n;
        longint prev, cur, nxt, nv, d;
        longint unsigned dm, sq, sum;
        res = '{32'd0, 32'd0, 1'b0, 1'b0};
        n   = (sh_points < NPTS) ? int'(sh_points) : NPTS;
        if (op == hef_pkg::OP_STEP)
        begin
            sum = 0;
            if (n >= 3)
            begin
                prev = shadow_grid[0];
                for (int x = 1; x + 1 < n; x++)
                begin
                    cur = shadow_grid[x];
                    nxt = shadow_grid[x+1];
                    nv  = cur + scale_toward_zero(nxt + prev - 2*cur, sh_diff_gain, 24)
                              + scale_toward_zero(sine_at_point(x), sh_time_step, 32);
                    if (nv > 64'sd2147483647)  nv = 64'sd2147483647;
                    if (nv < -64'sd2147483648) nv = -64'sd2147483648;
                    shadow_grid[x] = int'(nv);
                    d   = nv - cur;
                    dm  = (d < 0) ? longint'(0) - d : d;
                    sq  = dm * dm;
                    sum = (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
                    prev = cur;
                end
            end
            res.error_norm = floor_sqrt64(sum);
            res.converged  = (res.error_norm < sh_threshold);
        end
        else if (op == hef_pkg::OP_READ)
        begin
            if (int'(idx) < n) res.point_value = shadow_grid[idx];
            else               res.status = 1'b1;
        end
        else if (op == hef_pkg::OP_CLEAR)
        begin
            foreach (shadow_grid[i]) shadow_grid[i] = 0;
        end
        return res;
    endfunction

    // Receiver stall pattern
    always @(negedge clk)
        res_stall <= ($urandom_range(99) < recv_idle_pct);

    // Result checker
    always @(posedge clk)
    begin
        heat_result_t exp_r;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result word with nothing expected: value %h norm %h",
                         $time, point_value, error_norm);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (point_value !== exp_r.point_value)
                begin
                    $display("%0t: point_value expected %h actual %h",
                             $time, exp_r.point_value, point_value);
                    mismatch_count++;
                end
                if (error_norm !== exp_r.error_norm)
                begin
                    $display("%0t: error_norm expected %h actual %h",
                             $time, exp_r.error_norm, error_norm);
                    mismatch_count++;
                end
                if (converged !== exp_r.converged)
                begin
                    $display("%0t: converged expected %b actual %b",
                             $time, exp_r.converged, converged);
                    mismatch_count++;
                end
                if (status !== exp_r.status)
                begin
                    $display("%0t: status expected %b actual %b",
                             $time, exp_r.status, status);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("heat_equation_ftcs_step_test NOT OK");
            $finish;
        end
    end

    // Send one command word, predict its result on acceptance
    task automatic send_command(input logic [1:0] op, input logic [9:0] idx);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
        end
        @(negedge clk);
        cmd_valid   <= 1'b1;
        opcode      <= op;
        point_index <= idx;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
        expected_results.push_back(model_command(op, idx));
        case (op)
            hef_pkg::OP_STEP:  steps_sent++;
            hef_pkg::OP_READ:  reads_sent++;
            hef_pkg::OP_CLEAR: clears_sent++;
            default:           ;
        endcase
    endtask

    // Drain all outstanding results, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            hef_pkg::CFG_TIME_STEP:   sh_time_step = data;
            hef_pkg::CFG_GRID_STEP:   sh_grid_step = data;
            hef_pkg::CFG_DIFF_GAIN:   sh_diff_gain = data;
            hef_pkg::CFG_POINTS:      sh_points    = data[10:0];
            hef_pkg::CFG_CONV_THRESH: sh_threshold = data;
            default:                  ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Grid starts cleared; default registers give a zero-norm step
    task automatic test_reset_state();
        send_command(hef_pkg::OP_READ, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd1023);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd512);
        wait_idle();
    endtask

    // Extremes and special cases
    task automatic test_directed_cases();
        write_register(hef_pkg::CFG_TIME_STEP, 32'hFFFF_FFFF);
        write_register(hef_pkg::CFG_GRID_STEP, 32'h2000_0000);
        write_register(hef_pkg::CFG_DIFF_GAIN, 32'h0080_0000);
        write_register(hef_pkg::CFG_POINTS, 32'd8);
        write_register(hef_pkg::CFG_CONV_THRESH, 32'hFFFF_FFFF);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_STEP, 10'h3FF);
        for (int i = 0; i < 9; i++) send_command(hef_pkg::OP_READ, 10'(i));
        send_command(hef_pkg::OP_READ, 10'h3FF);
        send_command(OP_NONE, 10'h2AA);
        wait_idle();
        // saturating gain, zero threshold never converges
        write_register(hef_pkg::CFG_DIFF_GAIN, 32'hFFFF_FFFF);
        write_register(hef_pkg::CFG_CONV_THRESH, 32'd0);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd3);
        send_command(hef_pkg::OP_CLEAR, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd3);
        wait_idle();
        // too few points: step is a no-op
        write_register(hef_pkg::CFG_POINTS, 32'd2);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd1);
        wait_idle();
        // count beyond the grid is clamped
        write_register(hef_pkg::CFG_POINTS, 32'd1500);
        write_register(hef_pkg::CFG_DIFF_GAIN, 32'd0);
        send_command(hef_pkg::OP_STEP, 10'd0);
        send_command(hef_pkg::OP_READ, 10'd1022);
        wait_idle();
    endtask

    // Random traffic under one idling pattern
    task automatic test_random_traffic(input int s_pct, input int r_pct, input int items);
        int n, seg, r;
        logic [9:0] idx;
        sender_idle_pct = s_pct;
        recv_idle_pct   = r_pct;
        while (items > 0)
        begin
            wait_idle();
            r = $urandom_range(3);
            write_register(hef_pkg::CFG_CONV_THRESH, (r == 0) ? 32'd0 :
                           (r == 1) ? 32'hFFFF_FFFF :
                           (r == 2) ? $urandom_range(4095) : $urandom());
            write_register(hef_pkg::CFG_TIME_STEP,
                           ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom());
            write_register(hef_pkg::CFG_GRID_STEP, $urandom());
            write_register(hef_pkg::CFG_DIFF_GAIN,
                           ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1 << 23));
            n   = ($urandom_range(11) == 0) ? NPTS : $urandom_range(3, 40);
            seg = (n == NPTS) ? 6 : 30;
            write_register(hef_pkg::CFG_POINTS, 32'(n));
            for (int i = 0; i < seg && items > 0; i++)
            begin
                r   = $urandom_range(99);
                idx = ($urandom_range(4) == 0) ? 10'($urandom()) : 10'($urandom_range(n - 1));
                if      (r < 45) send_command(hef_pkg::OP_STEP, 10'($urandom()));
                else if (r < 90) send_command(hef_pkg::OP_READ, idx);
                else if (r < 94) send_command(hef_pkg::OP_CLEAR, 10'($urandom()));
                else             send_command(OP_NONE, 10'($urandom()));
                items--;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        build_sine_rom();
        foreach (shadow_grid[i]) shadow_grid[i] = 0;
        sh_time_step = hef_pkg::RST_TIME_STEP;
        sh_grid_step = hef_pkg::RST_GRID_STEP;
        sh_diff_gain = hef_pkg::RST_DIFF_GAIN;
        sh_points    = hef_pkg::RST_POINTS;
        sh_threshold = hef_pkg::RST_CONV_THRESH;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_directed_cases();
        test_random_traffic(19, 72, 180);
        test_random_traffic(72, 19, 180);
        test_random_traffic(0, 0, 180);

        $display("Covered %0d steps, %0d reads, %0d clears, %0d register writes",
                 steps_sent, reads_sent, clears_sent, cfg_writes);
        $display("under three idling patterns; %0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("heat_equation_ftcs_step_test OK");
        else
            $display("heat_equation_ftcs_step_test NOT OK");
        $finish;
    end

endmodule

// ===== heat_equation_ftcs_step.f =====
+incdir+hw/rtl
hw/rtl/hef_pkg.sv
hw/rtl/hef_ram.sv
hw/rtl/hef_sqrt.sv
hw/rtl/hef_ctrl.sv
hw/rtl/hef_datapath.sv
hw/rtl/heat_equation_ftcs_step.sv
hw/rtl/hef_checker.sv
tb/heat_equation_ftcs_step_test.sv
